>>> rtl/core/imcl_pkg.sv
// Shared constants, register codes and control types for the im2col address generator.
package imcl_pkg;

    // Upper bounds of the effective sizes
    localparam int MAX_IMAGE    = 256;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_KERNEL   = 11;
    localparam int MAX_BATCH    = 256;

    // Configuration register field widths
    localparam int IMG_W  = 9;
    localparam int CH_W   = 11;
    localparam int KER_W  = 4;
    localparam int STR_W  = 4;
    localparam int PAD_W  = 4;
    localparam int BAT_W  = 9;
    localparam int CFG_W  = 11;
    localparam int CFG_IDX_W = 3;

    // Counter and address widths
    localparam int SIZE_W = 9;   // out_size and output row / column counters
    localparam int BIDX_W = 8;
    localparam int CIDX_W = 10;
    localparam int TAP_W  = 4;
    localparam int OFS_W  = 42;
    localparam int NN_W   = 17;  // n*n
    localparam int NND_W  = 27;  // n*n*d
    localparam int SRC_W  = 35;  // widest partial source offset
    localparam int POS_W  = 14;  // window position before padding is removed

    localparam int DATA_W = 88;
    localparam int USER_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE  = 3'd0,
        CFG_CHAN   = 3'd1,
        CFG_KERNEL = 3'd2,
        CFG_STRIDE = 3'd3,
        CFG_PAD    = 3'd4,
        CFG_BATCH  = 3'd5
    } cfg_idx_t;

    function automatic logic cfg_known(input logic [CFG_IDX_W-1:0] idx);
        logic hit;
        case (cfg_idx_t'(idx))
            CFG_IMAGE, CFG_CHAN, CFG_KERNEL,
            CFG_STRIDE, CFG_PAD, CFG_BATCH: hit = 1'b1;
            default:                        hit = 1'b0;
        endcase
        return hit;
    endfunction

    typedef struct packed {
        logic restart;
        logic div_start;
        logic nn_load;
        logic nnd_load;
        logic size_load;
        logic take;
        logic addr_en;
        logic mul_en;
        logic out_load;
    } imcl_cmd_t;

    typedef struct packed {
        logic div_busy;
    } imcl_stat_t;

endpackage

>>> rtl/core/im2col_lowering_address_gen.sv
// Top level of the im2col lowering address generator.
//
//  channel   direction  contents
//  s_axis    in         tdata[0] advance, tdata[7:1] zero
//  m_axis    out        tdata source/dest offsets, tuser flags, tlast end of lowered row
//  cfg       in         cfg_we, cfg_index (register number), cfg_data
//
//  A request passes accept, window position, three products and a final sum into
//  the output register once the output slot is free; the next request is taken
//  on the cycle after the sum, even while that result still waits on m_axis_tready.
//  A write to a known register restarts the job and holds s_axis_tready low
//  in the setup and wait states while the divider works out the output size.
//  Reset values give a one-element job; no clearing pass is needed.
module im2col_lowering_address_gen
    import imcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] advance
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [41:0] source_offset, [83:42] dest_offset
    output logic [USER_W-1:0]    m_axis_tuser,   // [0] pad_zero, [1] job_done
    output logic                 m_axis_tlast,   // row_done
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    imcl_cmd_t        cmd;
    imcl_stat_t       stat;
    logic             cfg_hit;
    logic [OFS_W-1:0] source_offset;
    logic [OFS_W-1:0] dest_offset;
    logic             pad_zero;
    logic             row_done;
    logic             job_done;

    assign cfg_hit = cfg_we && cfg_known(cfg_index);

    imcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_hit   (cfg_hit),
        .in_valid  (s_axis_tvalid),
        .advance   (s_axis_tdata[0]),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    imcl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stat          (stat),
        .source_offset (source_offset),
        .pad_zero      (pad_zero),
        .dest_offset   (dest_offset),
        .row_done      (row_done),
        .job_done      (job_done)
    );

    assign m_axis_tdata = {(DATA_W - 2*OFS_W)'(0), dest_offset, source_offset};
    assign m_axis_tuser = {job_done, pad_zero};
    assign m_axis_tlast = row_done;

endmodule

>>> rtl/core/imcl_div.sv
// Restoring divider, one quotient bit per cycle, for the output size.
module imcl_div
    import imcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] dividend,
    input  logic [STR_W-1:0]  divisor,
    output logic              busy,
    output logic [SIZE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SIZE_W + 1);

    logic [SIZE_W-1:0] quo_reg, quo_next;
    logic [STR_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STR_W-1:0]  div_reg;
    logic              busy_reg, busy_next;
    logic [STR_W:0]    trial;

    always_comb
    begin
        trial     = {rem_reg[STR_W-1:0], quo_reg[SIZE_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SIZE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[SIZE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SIZE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/imcl_ctrl.sv
// Sequencer for setup after a register write and for the per-request address stages.
module imcl_ctrl
    import imcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_hit,
    input  logic       in_valid,
    input  logic       advance,
    input  logic       out_ready,
    input  imcl_stat_t stat,
    output logic       in_ready,
    output logic       out_valid,
    output imcl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WAIT,
        S_ADDR,
        S_MUL,
        S_SUM
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                // a request with advance low is taken and dropped
                if (in_valid && advance)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_SETUP:
            begin
                cmd.div_start = 1'b1;
                cmd.nn_load   = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                cmd.nnd_load = 1'b1;
                if (!stat.div_busy)
                begin
                    cmd.size_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // hold until the output slot frees
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_hit)
        begin
            cmd         = '0;
            cmd.restart = 1'b1;
            state_next  = S_SETUP;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/imcl_dp.sv
// Datapath: configuration, loop counters, size divider and source / destination offsets.
module imcl_dp
    import imcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  imcl_cmd_t            cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output imcl_stat_t           stat,
    output logic [OFS_W-1:0]     source_offset,
    output logic                 pad_zero,
    output logic [OFS_W-1:0]     dest_offset,
    output logic                 row_done,
    output logic                 job_done
);

    // Configuration
    logic [IMG_W-1:0] image_reg;
    logic [CH_W-1:0]  chan_cfg_reg;
    logic [KER_W-1:0] kernel_reg;
    logic [STR_W-1:0] stride_reg;
    logic [PAD_W-1:0] pad_reg;
    logic [BAT_W-1:0] batch_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_reg     <= IMG_W'(1);
            chan_cfg_reg  <= CH_W'(1);
            kernel_reg    <= KER_W'(1);
            stride_reg    <= STR_W'(1);
            pad_reg       <= '0;
            batch_cfg_reg <= BAT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_IMAGE:  image_reg     <= cfg_data[IMG_W-1:0];
                CFG_CHAN:   chan_cfg_reg  <= cfg_data[CH_W-1:0];
                CFG_KERNEL: kernel_reg    <= cfg_data[KER_W-1:0];
                CFG_STRIDE: stride_reg    <= cfg_data[STR_W-1:0];
                CFG_PAD:    pad_reg       <= cfg_data[PAD_W-1:0];
                CFG_BATCH:  batch_cfg_reg <= cfg_data[BAT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, large values saturate (stride excepted)
    logic [IMG_W-1:0] eff_n;
    logic [CH_W-1:0]  eff_d;
    logic [KER_W-1:0] eff_k;
    logic [STR_W-1:0] eff_s;
    logic [BAT_W-1:0] eff_b;

    always_comb
    begin
        eff_n = (image_reg == '0) ? IMG_W'(1) :
                (image_reg > IMG_W'(MAX_IMAGE)) ? IMG_W'(MAX_IMAGE) : image_reg;
        eff_d = (chan_cfg_reg == '0) ? CH_W'(1) :
                (chan_cfg_reg > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : chan_cfg_reg;
        eff_k = (kernel_reg == '0) ? KER_W'(1) :
                (kernel_reg > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_reg;
        eff_s = (stride_reg == '0) ? STR_W'(1) : stride_reg;
        eff_b = (batch_cfg_reg == '0) ? BAT_W'(1) :
                (batch_cfg_reg > BAT_W'(MAX_BATCH)) ? BAT_W'(MAX_BATCH) : batch_cfg_reg;
    end

    // Output size m = (n + 2p - k) / s + 1
    logic [SIZE_W:0]   span;
    logic              span_ge;
    logic [SIZE_W:0]   span_diff;
    logic [SIZE_W-1:0] quotient;
    logic              div_busy;

    assign span      = (SIZE_W+1)'(eff_n) + (SIZE_W+1)'({pad_reg, 1'b0});
    assign span_ge   = span >= (SIZE_W+1)'(eff_k);
    assign span_diff = span - (SIZE_W+1)'(eff_k);

    imcl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (span_ge ? span_diff[SIZE_W-1:0] : '0),
        .divisor  (eff_s),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign stat.div_busy = div_busy;

    logic [SIZE_W-1:0] size_reg;
    logic [NN_W-1:0]   nn_reg;
    logic [NND_W-1:0]  nnd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(1);
            nn_reg   <= NN_W'(1);
            nnd_reg  <= NND_W'(1);
        end
        else
        begin
            if (cmd.size_load)
            begin
                size_reg <= span_ge ? quotient + SIZE_W'(1) : SIZE_W'(1);
            end
            if (cmd.nn_load)
            begin
                nn_reg <= NN_W'(eff_n) * NN_W'(eff_n);
            end
            if (cmd.nnd_load)
            begin
                nnd_reg <= NND_W'(nn_reg) * NND_W'(eff_d);
            end
        end
    end

    // Loop counters: batch, output row, output column, channel, tap row, tap column
    logic [BIDX_W-1:0] bat_reg,  bat_next;
    logic [SIZE_W-1:0] orow_reg, orow_next;
    logic [SIZE_W-1:0] ocol_reg, ocol_next;
    logic [CIDX_W-1:0] chan_reg, chan_next;
    logic [TAP_W-1:0]  trow_reg, trow_next;
    logic [TAP_W-1:0]  tcol_reg, tcol_next;
    logic [OFS_W-1:0]  dest_reg, dest_next;
    logic tcol_last, trow_last, chan_last, ocol_last, orow_last, bat_last;
    logic last_row, last_job;

    always_comb
    begin
        tcol_last = (TAP_W'(tcol_reg) + TAP_W'(1)) >= eff_k;
        trow_last = (TAP_W'(trow_reg) + TAP_W'(1)) >= eff_k;
        chan_last = (CH_W'(chan_reg) + CH_W'(1)) >= eff_d;
        ocol_last = ((SIZE_W+1)'(ocol_reg) + (SIZE_W+1)'(1)) >= (SIZE_W+1)'(size_reg);
        orow_last = ((SIZE_W+1)'(orow_reg) + (SIZE_W+1)'(1)) >= (SIZE_W+1)'(size_reg);
        bat_last  = (BAT_W'(bat_reg) + BAT_W'(1)) >= eff_b;
        last_row  = chan_last && trow_last && tcol_last;
        last_job  = last_row && ocol_last && orow_last && bat_last;

        bat_next  = bat_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        chan_next = chan_reg;
        trow_next = trow_reg;
        tcol_next = tcol_reg;
        dest_next = dest_reg;
        if (last_job)
        begin
            bat_next  = '0;
            orow_next = '0;
            ocol_next = '0;
            chan_next = '0;
            trow_next = '0;
            tcol_next = '0;
            dest_next = '0;
        end
        else
        begin
            dest_next = dest_reg + OFS_W'(1);
            tcol_next = tcol_last ? '0 : tcol_reg + TAP_W'(1);
            if (tcol_last)
            begin
                trow_next = trow_last ? '0 : trow_reg + TAP_W'(1);
                if (trow_last)
                begin
                    chan_next = chan_last ? '0 : chan_reg + CIDX_W'(1);
                    if (chan_last)
                    begin
                        ocol_next = ocol_last ? '0 : ocol_reg + SIZE_W'(1);
                        if (ocol_last)
                        begin
                            orow_next = orow_last ? '0 : orow_reg + SIZE_W'(1);
                            if (orow_last)
                            begin
                                bat_next = bat_reg + BIDX_W'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_reg  <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            chan_reg <= '0;
            trow_reg <= '0;
            tcol_reg <= '0;
            dest_reg <= '0;
        end
        else if (cmd.restart)
        begin
            bat_reg  <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            chan_reg <= '0;
            trow_reg <= '0;
            tcol_reg <= '0;
            dest_reg <= '0;
        end
        else if (cmd.take)
        begin
            bat_reg  <= bat_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
            chan_reg <= chan_next;
            trow_reg <= trow_next;
            tcol_reg <= tcol_next;
            dest_reg <= dest_next;
        end
    end

    // Snapshot of the counters for the request in flight
    logic [BIDX_W-1:0] snap_bat_reg;
    logic [SIZE_W-1:0] snap_orow_reg;
    logic [SIZE_W-1:0] snap_ocol_reg;
    logic [CIDX_W-1:0] snap_chan_reg;
    logic [TAP_W-1:0]  snap_trow_reg;
    logic [TAP_W-1:0]  snap_tcol_reg;
    logic [OFS_W-1:0]  snap_dest_reg;
    logic              snap_row_done_reg;
    logic              snap_job_done_reg;

    // Window position in the padded image, padding removed
    logic [POS_W-1:0]  row_pos, col_pos, row_off, col_off;
    logic              pad_now;
    logic [IMG_W-1:0]  row_idx_reg, col_idx_reg;
    logic              pad_reg_s;

    always_comb
    begin
        row_pos = POS_W'(snap_orow_reg) * POS_W'(eff_s) + POS_W'(snap_trow_reg);
        col_pos = POS_W'(snap_ocol_reg) * POS_W'(eff_s) + POS_W'(snap_tcol_reg);
        row_off = row_pos - POS_W'(pad_reg);
        col_off = col_pos - POS_W'(pad_reg);
        pad_now = (row_pos < POS_W'(pad_reg)) || (col_pos < POS_W'(pad_reg))
               || (row_off >= POS_W'(eff_n)) || (col_off >= POS_W'(eff_n));
    end

    logic [SRC_W-1:0]       prod_bat_reg;
    logic [NND_W-1:0]       prod_chan_reg;
    logic [2*IMG_W-1:0]     prod_row_reg;
    logic [SRC_W-1:0]       src_sum;

    assign src_sum = prod_bat_reg + SRC_W'(prod_chan_reg) + SRC_W'(prod_row_reg)
                   + SRC_W'(col_idx_reg);

    logic [OFS_W-1:0] src_out_reg;
    logic             pad_out_reg;
    logic [OFS_W-1:0] dest_out_reg;
    logic             row_done_out_reg;
    logic             job_done_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            snap_bat_reg      <= bat_reg;
            snap_orow_reg     <= orow_reg;
            snap_ocol_reg     <= ocol_reg;
            snap_chan_reg     <= chan_reg;
            snap_trow_reg     <= trow_reg;
            snap_tcol_reg     <= tcol_reg;
            snap_dest_reg     <= dest_reg;
            snap_row_done_reg <= last_row;
            snap_job_done_reg <= last_job;
        end
        if (cmd.addr_en)
        begin
            row_idx_reg <= row_off[IMG_W-1:0];
            col_idx_reg <= col_off[IMG_W-1:0];
            pad_reg_s   <= pad_now;
        end
        if (cmd.mul_en)
        begin
            prod_bat_reg  <= SRC_W'(snap_bat_reg) * SRC_W'(nnd_reg);
            prod_chan_reg <= NND_W'(snap_chan_reg) * NND_W'(nn_reg);
            prod_row_reg  <= (2*IMG_W)'(row_idx_reg) * (2*IMG_W)'(eff_n);
        end
        if (cmd.out_load)
        begin
            src_out_reg      <= pad_reg_s ? '0 : OFS_W'(src_sum);
            pad_out_reg      <= pad_reg_s;
            dest_out_reg     <= snap_dest_reg;
            row_done_out_reg <= snap_row_done_reg;
            job_done_out_reg <= snap_job_done_reg;
        end
    end

    assign source_offset = src_out_reg;
    assign pad_zero      = pad_out_reg;
    assign dest_offset   = dest_out_reg;
    assign row_done      = row_done_out_reg;
    assign job_done      = job_done_out_reg;

endmodule
